FILE: hdl/duty_cycle_monitor_unit_assert.svh
// Assertion macros shared by the duty-cycle monitor modules.
`ifndef DUTY_CYCLE_MONITOR_UNIT_ASSERT_SVH
`define DUTY_CYCLE_MONITOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DCM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/dcm_pkg.sv
// Types and constants shared by the duty-cycle monitor modules.
package dcm_pkg;

  localparam int unsigned DutyW = 14;
  localparam logic [DutyW-1:0] DUTY_FULL = 14'd10000;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] DEBOUNCE_RST = 16'd300;
  localparam logic [7:0]  WALL_TICK_RST = 8'd16;
  localparam logic [7:0]  WHOLE_RST = 8'd16;
  localparam logic [9:0]  FRAC_RST = 10'd384;

  localparam logic [10:0] FRAC_ONE = 11'd1000;
  localparam logic [10:0] FRAC_TWO = 11'd2000;

  // Timer count times 8/125 by reciprocal: exact for every 8-bit count.
  localparam logic [13:0] TIMER_RECIP = 14'd8389;
  localparam int unsigned RecipShift = 20;
  localparam int unsigned TermW = 5;

  typedef enum logic [1:0] {
    KIND_WALL  = 2'd0,
    KIND_OVF   = 2'd1,
    KIND_PRESS = 2'd2
  } dcm_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE  = 2'd0,
    CFG_WALL_TICK = 2'd1,
    CFG_WHOLE     = 2'd2,
    CFG_FRAC      = 2'd3
  } dcm_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SNAP,
    ST_DECIDE,
    ST_RATIO,
    ST_FINISH
  } dcm_state_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SHIFT,
    PH_ADD
  } dcm_phase_e;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [7:0]  wall_tick_ms;
    logic [7:0]  whole_ms;
    logic [9:0]  frac_k;
  } dcm_cfg_t;

  typedef struct packed {
    logic start;
  } dcm_ratio_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dcm_ratio_sts_t;

endpackage

FILE: hdl/dcm_regs.sv
// Configuration register file of the duty-cycle monitor.
module dcm_regs import dcm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output dcm_cfg_t            cfg_o
);

  dcm_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (dcm_cfg_idx_e'(cfg_index_i))
        CFG_DEBOUNCE:  cfg_d.debounce_ms  = cfg_data_i;
        CFG_WALL_TICK: cfg_d.wall_tick_ms = cfg_data_i[7:0];
        CFG_WHOLE:     cfg_d.whole_ms     = cfg_data_i[7:0];
        CFG_FRAC:      cfg_d.frac_k       = cfg_data_i[9:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms  <= DEBOUNCE_RST;
      cfg_q.wall_tick_ms <= WALL_TICK_RST;
      cfg_q.whole_ms     <= WHOLE_RST;
      cfg_q.frac_k       <= FRAC_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: hdl/dcm_ratio.sv
// Iterative unit that works out active times 10000 over wall time, one step a cycle.
`include "duty_cycle_monitor_unit_assert.svh"

module dcm_ratio import dcm_pkg::*; #(
  parameter int unsigned W = 31
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dcm_ratio_req_t   req_i,
  input  logic [W-1:0]     a_i,
  input  logic [W-1:0]     w_i,
  output dcm_ratio_sts_t   sts_o,
  output logic [DutyW-1:0] q_o
);

  dcm_phase_e       phase_q, phase_d;
  logic [W:0]       rem_q, rem_d;
  logic [DutyW-1:0] q_q, q_d;
  logic [3:0]       bit_q, bit_d;
  logic             done_q, done_d;
  logic [W:0]       x;
  logic             ge;

  // The remainder stays below the divisor, so its top bit is always clear.
  assign x  = (phase_q == PH_ADD) ? rem_q + {1'b0, a_i} : {rem_q[W-1:0], 1'b0};
  assign ge = x >= {1'b0, w_i};

  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    q_d     = q_q;
    bit_d   = bit_q;
    done_d  = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (req_i.start) begin
          rem_d   = '0;
          q_d     = '0;
          bit_d   = 4'(DutyW - 1);
          phase_d = PH_SHIFT;
        end
      end
      PH_SHIFT: begin
        rem_d = ge ? x - {1'b0, w_i} : x;
        q_d   = {q_q[DutyW-2:0], ge};
        if (DUTY_FULL[bit_q]) begin
          phase_d = PH_ADD;
        end else if (bit_q == 4'd0) begin
          phase_d = PH_IDLE;
          done_d  = 1'b1;
        end else begin
          bit_d = bit_q - 4'd1;
        end
      end
      PH_ADD: begin
        rem_d = ge ? x - {1'b0, w_i} : x;
        q_d   = q_q + DutyW'(ge);
        if (bit_q == 4'd0) begin
          phase_d = PH_IDLE;
          done_d  = 1'b1;
        end else begin
          bit_d   = bit_q - 4'd1;
          phase_d = PH_SHIFT;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
      bit_q   <= '0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    q_q   <= q_d;
  end

  assign sts_o.busy = phase_q != PH_IDLE;
  assign sts_o.done = done_q;
  assign q_o        = q_q;

  `DCM_ASSERT_NOW(a_no_restart, clk_i, rst_ni, req_i.start, phase_q == PH_IDLE, "ratio restarted while busy")
  `DCM_ASSERT_NOW(a_add_on_set_bit, clk_i, rst_ni, phase_q == PH_ADD, DUTY_FULL[bit_q], "add step on a clear scale bit")
  `DCM_ASSERT_NOW(a_quot_range, clk_i, rst_ni, done_q, q_q < DUTY_FULL, "ratio quotient out of range")

endmodule

FILE: hdl/duty_cycle_monitor_unit.sv
// Top level of the duty-cycle monitor: clocks, debounce, snapshots and duty result.
// A wall tick, timer overflow or unused kind is handled in idle. A press goes
// to check, back to idle if the debounce window rejects it, else via snap and
// decide to finish if wall time is zero or active time has reached it, else
// via the ratio state, where the compare-and-subtract unit forms the duty
// cycle, one remainder step per cycle over the fourteen quotient bits. The
// block stalls its input while a press is worked on; a finished result sits in
// the output register, and a new request is taken while it waits there.
`include "duty_cycle_monitor_unit_assert.svh"

module duty_cycle_monitor_unit import dcm_pkg::*; #(
  parameter int unsigned TIME_BITS = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          kind_i,
  input  logic [7:0]          timer_count_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [30:0]         boot_time_ms_o,
  output logic [30:0]         active_ms_o,
  output logic [DutyW-1:0]    duty_hundredths_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  dcm_cfg_t       cfg;
  dcm_state_e     state_q, state_d;
  dcm_ratio_req_t ratio_req;
  dcm_ratio_sts_t ratio_sts;
  logic [DutyW-1:0] ratio_q;

  logic [TIME_BITS-1:0] wall_q, wall_d;
  logic [TIME_BITS-1:0] act_whole_q, act_whole_d;
  logic [9:0]           act_frac_q, act_frac_d;
  logic [TIME_BITS-1:0] last_press_q, last_press_d;
  logic [TIME_BITS-1:0] last_act_q, last_act_d;
  logic [7:0]           count_q, count_d;
  logic [TermW-1:0]     term_q, term_d;
  logic [DutyW-1:0]     duty_q, duty_d;

  logic                 out_valid_q, out_valid_d;
  logic [30:0]          out_boot_q, out_act_q;
  logic [DutyW-1:0]     out_duty_q;
  logic                 load;

  logic                 in_accept;
  logic [10:0]          frac_sum;
  logic [10:0]          frac_sub;
  logic [1:0]           frac_carry;
  logic [TIME_BITS-1:0] interval;
  logic [24:0]          term_prod;
  logic [TIME_BITS+30:0] boot_ext, act_ext;

  dcm_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dcm_ratio #(
    .W (TIME_BITS)
  ) u_ratio (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ratio_req),
    .a_i    (last_act_q),
    .w_i    (last_press_q),
    .sts_o  (ratio_sts),
    .q_o    (ratio_q)
  );

  assign in_stall_o = state_q != ST_IDLE;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign frac_sum = {1'b0, act_frac_q} + {1'b0, cfg.frac_k};
  always_comb begin
    if (frac_sum >= FRAC_TWO) begin
      frac_carry = 2'd2;
      frac_sub   = FRAC_TWO;
    end else if (frac_sum >= FRAC_ONE) begin
      frac_carry = 2'd1;
      frac_sub   = FRAC_ONE;
    end else begin
      frac_carry = 2'd0;
      frac_sub   = '0;
    end
  end

  assign interval  = wall_q - last_press_q;
  assign term_prod = 25'({count_q, 3'b000}) * 25'(TIMER_RECIP);

  assign load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d         = state_q;
    wall_d          = wall_q;
    act_whole_d     = act_whole_q;
    act_frac_d      = act_frac_q;
    last_press_d    = last_press_q;
    last_act_d      = last_act_q;
    count_d         = count_q;
    term_d          = term_q;
    duty_d          = duty_q;
    ratio_req.start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (dcm_kind_e'(kind_i))
            KIND_WALL: wall_d = wall_q + TIME_BITS'(cfg.wall_tick_ms);
            KIND_OVF: begin
              act_whole_d = act_whole_q + TIME_BITS'(cfg.whole_ms)
                            + TIME_BITS'(frac_carry);
              act_frac_d  = 10'(frac_sum - frac_sub);
            end
            KIND_PRESS: begin
              count_d = timer_count_i;
              state_d = ST_CHECK;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CHECK: begin
        if (interval > TIME_BITS'(cfg.debounce_ms)) begin
          last_press_d = wall_q;
          term_d       = term_prod[RecipShift +: TermW];
          state_d      = ST_SNAP;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SNAP: begin
        last_act_d = act_whole_q + TIME_BITS'(term_q);
        state_d    = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (last_press_q == '0) begin
          duty_d  = '0;
          state_d = ST_FINISH;
        end else if (last_act_q >= last_press_q) begin
          duty_d  = DUTY_FULL;
          state_d = ST_FINISH;
        end else begin
          ratio_req.start = 1'b1;
          state_d         = ST_RATIO;
        end
      end
      ST_RATIO: begin
        if (ratio_sts.done) begin
          duty_d  = ratio_q;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign boot_ext = {{31{1'b0}}, last_press_q};
  assign act_ext  = {{31{1'b0}}, last_act_q};

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      wall_q       <= '0;
      act_whole_q  <= '0;
      act_frac_q   <= '0;
      last_press_q <= '0;
      last_act_q   <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      wall_q       <= wall_d;
      act_whole_q  <= act_whole_d;
      act_frac_q   <= act_frac_d;
      last_press_q <= last_press_d;
      last_act_q   <= last_act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    term_q  <= term_d;
    duty_q  <= duty_d;
    if (load) begin
      out_boot_q <= boot_ext[30:0];
      out_act_q  <= act_ext[30:0];
      out_duty_q <= duty_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign boot_time_ms_o    = out_boot_q;
  assign active_ms_o       = out_act_q;
  assign duty_hundredths_o = out_duty_q;

  `DCM_ASSERT_NOW(a_duty_range, clk_i, rst_ni, out_valid_q, out_duty_q <= DUTY_FULL, "duty result above full scale")
  `DCM_ASSERT_NOW(a_zero_wall, clk_i, rst_ni, load && (last_press_q == '0), duty_q == '0, "non-zero duty with zero wall time")
  `DCM_ASSERT_NOW(a_ratio_owned, clk_i, rst_ni, ratio_sts.busy, state_q == ST_RATIO, "ratio unit busy outside its state")
  `DCM_ASSERT_NEXT(a_frac_bound, clk_i, rst_ni, 1'b1, act_frac_q < FRAC_ONE[9:0], "active fraction reached one millisecond")

endmodule
